/* rtl/ebd_pkg.sv */
// Shared types for the HTML empty-body detector: byte classes and queue token.
`default_nettype none

package ebd_pkg;

    typedef enum logic [3:0] {
        CLS_LT    = 4'd0,
        CLS_SLASH = 4'd1,
        CLS_B     = 4'd2,
        CLS_O     = 4'd3,
        CLS_D     = 4'd4,
        CLS_Y     = 4'd5,
        CLS_GT    = 4'd6,
        CLS_BANG  = 4'd7,
        CLS_DASH  = 4'd8,
        CLS_BLANK = 4'd9,
        CLS_OTHER = 4'd10
    } byte_cls_t;

    typedef struct packed {
        byte_cls_t cls;
        logic      last;
    } token_t;

endpackage

`default_nettype wire

/* rtl/ebd_front.sv */
// Front end: accepts text bytes and reduces each one to a byte class token.
`default_nettype none

module ebd_front
    import ebd_pkg::*;
(
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_text
    input  wire logic       q_full,
    output logic            q_push,
    output token_t          q_token
);

    function automatic byte_cls_t classify(input logic [7:0] b);
        byte_cls_t c;
        unique case (b) inside
            8'h3C:                                    c = CLS_LT;
            8'h2F:                                    c = CLS_SLASH;
            8'h62:                                    c = CLS_B;
            8'h6F:                                    c = CLS_O;
            8'h64:                                    c = CLS_D;
            8'h79:                                    c = CLS_Y;
            8'h3E:                                    c = CLS_GT;
            8'h21:                                    c = CLS_BANG;
            8'h2D:                                    c = CLS_DASH;
            8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B: c = CLS_BLANK;
            default:                                  c = CLS_OTHER;
        endcase
        return c;
    endfunction

    assign s_tready     = !q_full;
    assign q_push       = s_tvalid && !q_full;
    assign q_token.cls  = classify(s_tdata);
    assign q_token.last = s_tlast;

endmodule

`default_nettype wire

/* rtl/ebd_fifo.sv */
// Short token queue between the front end and the scanner.
`default_nettype none

module ebd_fifo
    import ebd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire token_t din,
    output logic        full,
    input  wire logic   pop,
    output token_t      dout,
    output logic        valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

/* rtl/ebd_scan.sv */
// Back end: tag matchers, body region scanner and result register.
`default_nettype none

module ebd_scan
    import ebd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   q_valid,
    input  wire token_t q_token,
    output logic        q_pop,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output logic [7:0]  m_tdata    // [0] body_empty, [1] malformed, [7:2] zero
);

    typedef enum logic [6:0] {
        PH_WAIT    = 7'b0000001,
        PH_BLANKS  = 7'b0000010,
        PH_LT      = 7'b0000100,
        PH_BANG    = 7'b0001000,
        PH_DASH    = 7'b0010000,
        PH_COMMENT = 7'b0100000,
        PH_FULL    = 7'b1000000
    } phase_t;

    function automatic byte_cls_t close_cls(input logic [2:0] idx);
        byte_cls_t c;
        unique case (idx)
            3'd0:    c = CLS_LT;
            3'd1:    c = CLS_SLASH;
            3'd2:    c = CLS_B;
            3'd3:    c = CLS_O;
            3'd4:    c = CLS_D;
            3'd5:    c = CLS_Y;
            3'd6:    c = CLS_GT;
            default: c = CLS_OTHER;
        endcase
        return c;
    endfunction

    function automatic byte_cls_t open_cls(input logic [2:0] idx);
        byte_cls_t c;
        unique case (idx)
            3'd0:    c = CLS_LT;
            3'd1:    c = CLS_B;
            3'd2:    c = CLS_O;
            3'd3:    c = CLS_D;
            3'd4:    c = CLS_Y;
            default: c = CLS_OTHER;
        endcase
        return c;
    endfunction

    logic [2:0] close_cnt_reg, close_cnt_next;
    logic [2:0] open_cnt_reg, open_cnt_next;
    logic       open_found_reg, open_found_next;
    logic       open_closed_reg, open_closed_next;
    logic       close_found_reg, close_found_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] dash_reg, dash_next;
    logic       v_empty_reg, v_empty_next;
    logic       v_mal_reg, v_mal_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [1:0] res_reg, res_next;

    logic       is_lt;
    logic       close_hit, open_hit, completed, open_done;
    logic [2:0] close_inc, open_inc, new_close;
    logic       mal;

    assign q_pop = q_valid && (!q_token.last || !m_tvalid_reg || m_tready);

    assign is_lt     = (q_token.cls == CLS_LT);
    assign close_hit = (q_token.cls == close_cls(close_cnt_reg));
    assign close_inc = close_cnt_reg + 3'd1;
    assign completed = close_hit && (close_inc == 3'd7);
    assign new_close = completed ? 3'd0 : (close_hit ? close_inc : (is_lt ? 3'd1 : 3'd0));
    assign open_hit  = (q_token.cls == open_cls(open_cnt_reg));
    assign open_inc  = open_cnt_reg + 3'd1;
    assign open_done = open_hit && (open_inc == 3'd5);

    always_comb begin
        close_cnt_next   = close_cnt_reg;
        open_cnt_next    = open_cnt_reg;
        open_found_next  = open_found_reg;
        open_closed_next = open_closed_reg;
        close_found_next = close_found_reg;
        phase_next       = phase_reg;
        dash_next        = dash_reg;
        v_empty_next     = v_empty_reg;
        v_mal_next       = v_mal_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        res_next         = res_reg;

        if (q_pop && !close_found_reg) begin
            close_cnt_next = new_close;
            if (completed) begin
                close_found_next = 1'b1;
                if (!open_closed_reg) begin
                    v_mal_next = 1'b1;
                end else begin
                    v_empty_next = (phase_reg == PH_LT);
                end
            end else if (!open_found_reg) begin
                if (open_done) begin
                    open_found_next = 1'b1;
                    open_cnt_next   = 3'd0;
                end else if (open_hit) begin
                    open_cnt_next = open_inc;
                end else begin
                    open_cnt_next = is_lt ? 3'd1 : 3'd0;
                end
            end else if (!open_closed_reg) begin
                if (q_token.cls == CLS_GT) begin
                    open_closed_next = 1'b1;
                    phase_next       = PH_BLANKS;
                end
            end else begin
                unique case (phase_reg)
                    PH_BLANKS: begin
                        if (is_lt) begin
                            phase_next = PH_LT;
                        end else if (q_token.cls != CLS_BLANK) begin
                            phase_next = PH_FULL;
                        end
                    end
                    PH_LT: begin
                        if (q_token.cls == CLS_BANG && close_cnt_reg == 3'd1) begin
                            phase_next = PH_BANG;
                        end else if (new_close != close_inc) begin
                            phase_next = PH_FULL;
                        end
                    end
                    PH_BANG: begin
                        phase_next = (q_token.cls == CLS_DASH) ? PH_DASH : PH_FULL;
                    end
                    PH_DASH: begin
                        if (q_token.cls == CLS_DASH) begin
                            phase_next = PH_COMMENT;
                            dash_next  = 2'd2;
                        end else begin
                            phase_next = PH_FULL;
                        end
                    end
                    PH_COMMENT: begin
                        if (q_token.cls == CLS_DASH) begin
                            if (dash_reg < 2'd2) begin
                                dash_next = dash_reg + 2'd1;
                            end
                        end else if (q_token.cls == CLS_GT && dash_reg == 2'd2) begin
                            phase_next = PH_BLANKS;
                            dash_next  = 2'd0;
                        end else begin
                            dash_next = 2'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        mal = !close_found_next || v_mal_next;

        if (q_pop && q_token.last) begin
            m_tvalid_next    = 1'b1;
            res_next         = {mal, mal || v_empty_next};
            close_cnt_next   = 3'd0;
            open_cnt_next    = 3'd0;
            open_found_next  = 1'b0;
            open_closed_next = 1'b0;
            close_found_next = 1'b0;
            phase_next       = PH_WAIT;
            dash_next        = 2'd0;
            v_empty_next     = 1'b1;
            v_mal_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_cnt_reg   <= 3'd0;
            open_cnt_reg    <= 3'd0;
            open_found_reg  <= 1'b0;
            open_closed_reg <= 1'b0;
            close_found_reg <= 1'b0;
            phase_reg       <= PH_WAIT;
            dash_reg        <= 2'd0;
            v_empty_reg     <= 1'b1;
            v_mal_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            close_cnt_reg   <= close_cnt_next;
            open_cnt_reg    <= open_cnt_next;
            open_found_reg  <= open_found_next;
            open_closed_reg <= open_closed_next;
            close_found_reg <= close_found_next;
            phase_reg       <= phase_next;
            dash_reg        <= dash_next;
            v_empty_reg     <= v_empty_next;
            v_mal_reg       <= v_mal_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, res_reg};

endmodule

`default_nettype wire

/* rtl/html_empty_body_detector.sv */
// Top level: one text byte per transaction in, one verdict per text out.
// Throughput: one byte per cycle; a final byte waits in the queue while the previous
// verdict is unaccepted, and s_tready drops once the queue holds FIFO_DEPTH tokens.
// m_tvalid rises once the final byte's token, written into the queue, leaves it and
// is scanned into the result register; it can wait there behind an unaccepted verdict.
// Reset: synchronous active-low aresetn clears queue, matchers and result valid.
`default_nettype none

module html_empty_body_detector
    import ebd_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] body_empty, [1] malformed, [7:2] zero
);

    logic   q_full, q_push, q_pop, q_valid;
    token_t q_in, q_out;

    ebd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_token  (q_in)
    );

    ebd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .valid   (q_valid)
    );

    ebd_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_token  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for html_empty_body_detector: directed and random HTML texts vs. a predictor.

module tb;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 40;

    localparam byte unsigned OPEN_TAG  [5] = '{"<", "b", "o", "d", "y"};
    localparam byte unsigned CLOSE_TAG [7] = '{"<", "/", "b", "o", "d", "y", ">"};
    localparam byte unsigned BLANK_SET [6] = '{8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B};

    typedef enum bit [2:0] {
        RG_WAIT, RG_BLANK, RG_LT, RG_BANG, RG_DASH, RG_COMMENT, RG_TEXT
    } region_t;

    typedef struct packed {
        bit body_empty;
        bit malformed;
    } verdict_t;

    typedef struct {
        string text;
        bit    lead_nul;
        bit    typed;
        bit    want_empty;
        bit    want_mal;
    } body_case_t;

    body_case_t body_cases [18] = '{
        '{"\377",                                 0, 1, 1, 1},
        '{"<body></body>",                        1, 1, 1, 0},
        '{"<body> x </body>",                     0, 1, 0, 0},
        '{"<body \377>\014\012\015\011\013 </body>", 0, 1, 1, 0},
        '{"<body><!-- c --></body>",              0, 1, 1, 0},
        '{"<body><!--></body>",                   0, 1, 1, 0},
        '{"<body><!---></body>",                  0, 0, 0, 0},
        '{"<body><!-- open</body>",               0, 1, 0, 0},
        '{"<html><body>",                         0, 1, 1, 1},
        '{"</body><body>",                        0, 1, 1, 1},
        '{"<body </body>",                        0, 1, 1, 1},
        '{"<body></body>tail",                    0, 0, 0, 0},
        '{"<body><p></body>",                     0, 1, 0, 0},
        '{"<body><!x></body>",                    0, 0, 0, 0},
        '{"<body><</body>",                       0, 0, 0, 0},
        '{"<BODY></BODY>",                        0, 1, 1, 1},
        '{"<bo<body>--></body>",                  0, 0, 0, 0},
        '{"<body><!-- a -- b ---></body>",        0, 0, 0, 0}
    };

    string comment_fill = "-> a<!";

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    // scanner state mirrored from the block
    bit [2:0] open_cnt      = 3'd0;
    bit       open_seen     = 1'b0;
    bit       open_gt       = 1'b0;
    bit [2:0] close_cnt     = 3'd0;
    bit       close_seen    = 1'b0;
    region_t  region        = RG_WAIT;
    bit [1:0] dashes        = 2'd0;
    bit       verdict_empty = 1'b1;
    bit       verdict_mal   = 1'b0;

    verdict_t verdict_q [$];

    int error_count   = 0;
    int bytes_sent    = 0;
    int texts_sent    = 0;
    int verdicts_seen = 0;
    int empty_seen    = 0;
    int mal_seen      = 0;
    int src_idle_pct  = 28;
    int sink_idle_pct = 28;
    bit hold_req      = 1'b0;

    html_empty_body_detector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] data_byte
        .s_tlast  (s_tlast),    // end_of_text
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [0] body_empty, [1] malformed, [7:2] zero
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("tb: mismatch on %s at verdict %0d: got %0d, want %0d",
                     what, verdicts_seen, got, want);
    endtask

    // Advances the scanner by one byte; returns 1 with the verdict on the final byte.
    function automatic bit scan_html_byte(input byte unsigned b, input bit last,
                                          output verdict_t v);
        bit [2:0] prev;
        bit [2:0] nxt;
        bit       done;
        bit       bad;
        v = '0;
        if (!close_seen) begin
            prev = close_cnt;
            done = 1'b0;
            if (prev < 3'd7 && b == CLOSE_TAG[prev]) begin
                nxt = prev + 3'd1;
                if (nxt == 3'd7) begin
                    done = 1'b1;
                    nxt  = 3'd0;
                end
            end else begin
                nxt = (b == "<") ? 3'd1 : 3'd0;
            end
            close_cnt = nxt;
            if (done) begin
                close_seen = 1'b1;
                if (!open_gt)
                    verdict_mal = 1'b1;
                else
                    verdict_empty = (region == RG_LT);
            end else if (!open_seen) begin
                if (open_cnt < 3'd5 && b == OPEN_TAG[open_cnt]) begin
                    open_cnt = open_cnt + 3'd1;
                    if (open_cnt == 3'd5) begin
                        open_seen = 1'b1;
                        open_cnt  = 3'd0;
                    end
                end else begin
                    open_cnt = (b == "<") ? 3'd1 : 3'd0;
                end
            end else if (!open_gt) begin
                if (b == ">") begin
                    open_gt = 1'b1;
                    region  = RG_BLANK;
                end
            end else begin
                case (region)
                    RG_BLANK: begin
                        if (b == "<")
                            region = RG_LT;
                        else if (!(b inside {8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B}))
                            region = RG_TEXT;
                    end
                    RG_LT: begin
                        if (b == "!" && prev == 3'd1)
                            region = RG_BANG;
                        else if (nxt != prev + 3'd1)
                            region = RG_TEXT;
                    end
                    RG_BANG: region = (b == "-") ? RG_DASH : RG_TEXT;
                    RG_DASH: begin
                        if (b == "-") begin
                            region = RG_COMMENT;
                            dashes = 2'd2;
                        end else begin
                            region = RG_TEXT;
                        end
                    end
                    RG_COMMENT: begin
                        if (b == "-") begin
                            if (dashes < 2'd2)
                                dashes = dashes + 2'd1;
                        end else if (b == ">" && dashes == 2'd2) begin
                            region = RG_BLANK;
                            dashes = 2'd0;
                        end else begin
                            dashes = 2'd0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (!last)
            return 1'b0;
        bad          = !close_seen || verdict_mal;
        v.body_empty = bad || verdict_empty;
        v.malformed  = bad;
        open_cnt      = 3'd0;
        open_seen     = 1'b0;
        open_gt       = 1'b0;
        close_cnt     = 3'd0;
        close_seen    = 1'b0;
        region        = RG_WAIT;
        dashes        = 2'd0;
        verdict_empty = 1'b1;
        verdict_mal   = 1'b0;
        return 1'b1;
    endfunction

    function automatic void append_text(ref byte unsigned t[$], input string s);
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
    endfunction

    function automatic void append_body_part(ref byte unsigned t[$]);
        case ($urandom_range(0, 9)) inside
            0, 1, 9: begin
                repeat ($urandom_range(1, 3))
                    t.push_back(BLANK_SET[$urandom_range(0, 5)]);
            end
            2, 3: begin
                append_text(t, "<!--");
                repeat ($urandom_range(0, 4)) t.push_back(comment_fill[$urandom_range(0, 5)]);
                append_text(t, "-->");
            end
            4: begin
                if ($urandom_range(0, 1) == 0)
                    append_text(t, "<!-->");
                else
                    append_text(t, "<!--->");
            end
            5: begin
                // comment opened with no closing --> appended
                append_text(t, "<!--");
                repeat ($urandom_range(0, 3)) t.push_back(comment_fill[$urandom_range(0, 5)]);
            end
            6: t.push_back(8'($urandom));
            7: begin
                append_text(t, "<");
                t.push_back(comment_fill[$urandom_range(0, 5)]);
            end
            8: begin
                append_text(t, "<!-");
                t.push_back(8'($urandom));
            end
            default: begin
                append_text(t, "</bo");
                t.push_back(8'($urandom));
            end
        endcase
    endfunction

    // Mostly well-formed documents; some noise, some with a byte dropped, cut short
    // or with the closing tag up front.
    task automatic build_text(ref byte unsigned t[$]);
        int kind;
        int at;
        t.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 10)) t.push_back(8'($urandom));
            return;
        end
        if (kind == 3)
            append_text(t, "</body>");
        repeat ($urandom_range(0, 2)) t.push_back(8'($urandom));
        append_text(t, "<body");
        if ($urandom_range(0, 2) == 0)
            append_text(t, " id=\"b\"");
        append_text(t, ">");
        repeat ($urandom_range(0, 4)) append_body_part(t);
        append_text(t, "</body>");
        repeat ($urandom_range(0, 2)) t.push_back(8'($urandom));
        at = $urandom_range(0, t.size() - 1);
        if (kind == 1)
            t.delete(at);
        else if (kind == 2)
            t = t[0:at];
    endtask

    task automatic send_text(ref byte unsigned t[$], input bit typed, input verdict_t want);
        verdict_t got;
        for (int k = 0; k < t.size(); k++) begin
            while ($urandom_range(0, 99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= t[k];
            s_tlast  <= (k == t.size() - 1);
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            if (scan_html_byte(t[k], k == t.size() - 1, got))
                verdict_q.push_back(typed ? want : got);
            bytes_sent++;
        end
        texts_sent++;
    endtask

    initial begin : sink
        verdict_t want;
        int       hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none pending", int'(m_tdata), 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.body_empty)
                        report_mismatch("body_empty", int'(m_tdata[0]),
                                        int'(want.body_empty));
                    if (m_tdata[1] !== want.malformed)
                        report_mismatch("malformed", int'(m_tdata[1]),
                                        int'(want.malformed));
                    if (m_tdata[7:2] !== 6'd0)
                        report_mismatch("tdata padding", int'(m_tdata[7:2]), 0);
                end
                verdicts_seen++;
                empty_seen += int'(m_tdata[0]);
                mal_seen   += int'(m_tdata[1]);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall = 0;
            else
                stall++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        byte unsigned txt [$];
        verdict_t     want;
        int           rand_texts;
        rand_texts = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (body_cases[i]) begin
            txt.delete();
            if (body_cases[i].lead_nul)
                txt.push_back(8'h00);
            append_text(txt, body_cases[i].text);
            want.body_empty = body_cases[i].want_empty;
            want.malformed  = body_cases[i].want_mal;
            send_text(txt, body_cases[i].typed, want);
        end

        while (bytes_sent < 430) begin
            build_text(txt);
            send_text(txt, 1'b0, '0);
            rand_texts++;
        end

        // no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (bytes_sent < 560) begin
            build_text(txt);
            send_text(txt, 1'b0, '0);
            rand_texts++;
        end

        // receiver holds off while texts keep coming
        hold_req = 1'b1;
        while (bytes_sent < 620) begin
            build_text(txt);
            send_text(txt, 1'b0, '0);
            rand_texts++;
        end

        // sender pauses until every verdict is back
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);

        src_idle_pct  = 28;
        sink_idle_pct = 28;
        while (bytes_sent < 700 || rand_texts < 10) begin
            build_text(txt);
            send_text(txt, 1'b0, '0);
            rand_texts++;
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("tb: %0d bytes in %0d texts (%0d directed cases), %0d verdicts checked",
                 bytes_sent, texts_sent, $size(body_cases), verdicts_seen);
        $display("tb: %0d verdicts empty, %0d malformed, %0d mismatches",
                 empty_seen, mal_seen, error_count);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ebd_pkg.sv
rtl/ebd_front.sv
rtl/ebd_fifo.sv
rtl/ebd_scan.sv
rtl/html_empty_body_detector.sv
tb/sv/tb.sv
